### design/linear_chirp_sample_top_macros.svh
// Assertion macros for the chirp sample top design file.
`ifndef LINEAR_CHIRP_SAMPLE_TOP_MACROS_SVH
`define LINEAR_CHIRP_SAMPLE_TOP_MACROS_SVH

// Condition implies consequence in the same cycle.
`define LCS_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// Condition implies consequence in the next cycle.
`define LCS_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

### design/lcs_pkg.sv
// Shared types, register indexes and sine table helpers for the chirp sample block.
`timescale 1ns / 1ps

package lcs_pkg;

  typedef logic signed [17:0] s18_t;

  typedef enum logic [2:0] {
    REG_START_FREQUENCY = 3'd0,
    REG_START_AMPLITUDE = 3'd1,
    REG_START_PHASE     = 3'd2,
    REG_AMPLITUDE_SLOPE = 3'd3,
    REG_CHIRP_RATE      = 3'd4
  } cfg_reg_t;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam int     TAYLOR_TERMS = 12;

  // Divide a Taylor term by (2k)(2k+1); all terms here are nonnegative.
  function automatic longint taylor_div(longint term, int k);
    case (k)
      1:       return term / 6;
      2:       return term / 20;
      3:       return term / 42;
      4:       return term / 72;
      5:       return term / 110;
      6:       return term / 156;
      7:       return term / 210;
      8:       return term / 272;
      9:       return term / 342;
      10:      return term / 420;
      11:      return term / 506;
      12:      return term / 600;
      default: return 64'sd0;
    endcase
  endfunction

endpackage

### design/lcs_sine_rom.sv
// Quarter-wave sine ROM with registered read.
`timescale 1ns / 1ps

module lcs_sine_rom #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [SINE_TABLE_BITS:0] addr,
  output logic [16:0]              data
);
  import lcs_pkg::*;

  localparam int QN = 1 << SINE_TABLE_BITS;

  typedef logic [16:0] rom_t [QN+1];

  function automatic rom_t build_rom();
    rom_t   tab;
    longint x;
    longint x2;
    longint term;
    longint sum;
    for (int i = 0; i <= QN; i++) begin
      x    = (HALF_PI_Q30 * longint'(i)) >>> SINE_TABLE_BITS;
      x2   = (x * x) >>> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= TAYLOR_TERMS; k++) begin
        term = taylor_div((term * x2) >>> 30, k);
        if (k % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      tab[i] = 17'((sum * 64'sd65536 + (64'sd1 <<< 29)) >>> 30);
    end
    return tab;
  endfunction

  localparam rom_t ROM = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data <= ROM[addr];
    end
  end

endmodule

### design/linear_chirp_sample_top.sv
// Linear chirp sample generator: seven-stage pipeline from time value to sample.
// Throughput: one item per cycle while the output is not stalled; nothing iterates, since every
// multiply and the single-port sine ROM read are registered in their own pipeline stage.
// A stall on the output freezes the whole pipeline in place.
// Reset clears all valid bits, holds both ready lines low and loads the register defaults.
`timescale 1ns / 1ps

module linear_chirp_sample_top #(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [24:0]        time_in,
  output logic               out_valid,
  input  logic               out_ready,
  output lcs_pkg::s18_t      sine_out,
  output lcs_pkg::s18_t      phase_out,
  output lcs_pkg::s18_t      envelope_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import lcs_pkg::*;

  logic [27:0]        start_frequency;
  logic signed [17:0] start_amplitude;
  logic [31:0]        start_phase;
  logic signed [17:0] amplitude_slope;
  logic signed [31:0] chirp_rate;

  logic advance;

  assign advance   = !out_valid || out_ready;
  assign in_ready  = advance && !rst;
  assign cfg_ready = !rst;

  // Configuration registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_frequency <= 28'd65536;
      start_amplitude <= 18'sd65536;
      start_phase     <= 32'd0;
      amplitude_slope <= 18'sd0;
      chirp_rate      <= 32'sd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_START_FREQUENCY: start_frequency <= cfg_data[27:0];
        REG_START_AMPLITUDE: start_amplitude <= $signed(cfg_data[17:0]);
        REG_START_PHASE:     start_phase     <= cfg_data;
        REG_AMPLITUDE_SLOPE: amplitude_slope <= $signed(cfg_data[17:0]);
        REG_CHIRP_RATE:      chirp_rate      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Valid bits per stage.
  logic v1, v2, v3, v4, v5, v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      out_valid <= v6;
    end
  end

  // Stage 1: frequency, time-squared and slope products.
  logic [52:0]        fprod1;
  logic [49:0]        tt1;
  logic signed [43:0] sprod1;

  always_ff @(posedge clk) begin
    if (advance) begin
      fprod1 <= 53'(start_frequency) * 53'(time_in);
      tt1    <= 50'(time_in) * 50'(time_in);
      sprod1 <= 44'(amplitude_slope) * $signed({19'd0, time_in});
    end
  end

  // Stage 2: rate partial products and saturated envelope.
  logic [33:0]        t2_comb;
  logic signed [19:0] env_sum;
  s18_t               env_sat;
  logic [31:0]        f2;
  logic signed [49:0] plo2;
  logic signed [49:0] phi2;
  s18_t               env2;

  assign t2_comb = tt1[49:16];
  assign env_sum = 20'(start_amplitude) + $signed(sprod1[43:24]);

  always_comb begin
    if (env_sum > 20'sd131071) begin
      env_sat = 18'sd131071;
    end else if (env_sum < -20'sd131072) begin
      env_sat = -18'sd131072;
    end else begin
      env_sat = env_sum[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f2   <= fprod1[39:8];
      plo2 <= 50'(chirp_rate) * $signed({33'd0, t2_comb[16:0]});
      phi2 <= 50'(chirp_rate) * $signed({33'd0, t2_comb[33:17]});
      env2 <= env_sat;
    end
  end

  // Stage 3: combine partial products into the rate term.
  logic signed [66:0] rsum;
  logic [31:0]        f3;
  logic [31:0]        r3;
  s18_t               env3;

  assign rsum = {{17{phi2[49]}}, phi2} * 67'sd131072 + {{17{plo2[49]}}, plo2};

  always_ff @(posedge clk) begin
    if (advance) begin
      f3   <= f2;
      r3   <= rsum[55:24];
      env3 <= env2;
    end
  end

  // Stage 4: phase accumulation, wraps mod one turn.
  logic [31:0] p4;
  s18_t        env4;

  always_ff @(posedge clk) begin
    if (advance) begin
      p4   <= start_phase + f3 + r3;
      env4 <= env3;
    end
  end

  // Stage 5: sine ROM lookup and phase mapping.
  localparam int QN = 1 << SINE_TABLE_BITS;

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [SINE_TABLE_BITS:0]   rom_addr;
  logic [16:0]                rom_data;
  s18_t                       phase_comb;
  logic                       neg5;
  s18_t                       phase5;
  s18_t                       env5;

  assign idx      = p4[29 -: SINE_TABLE_BITS];
  assign rom_addr = p4[30] ? (SINE_TABLE_BITS+1)'(QN) - {1'b0, idx} : {1'b0, idx};

  // Values above one turn-half wrap to the negative side.
  assign phase_comb = (p4[31:15] > 17'd65536) ? $signed({1'b1, p4[31:15]})
                                              : $signed({1'b0, p4[31:15]});

  lcs_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_rom (
    .clk (clk),
    .en  (advance),
    .addr(rom_addr),
    .data(rom_data)
  );

  always_ff @(posedge clk) begin
    if (advance) begin
      neg5   <= p4[31];
      phase5 <= phase_comb;
      env5   <= env4;
    end
  end

  // Stage 6: envelope times signed sine.
  s18_t               sine5;
  logic signed [35:0] prod6;
  s18_t               phase6;
  s18_t               env6;

  assign sine5 = neg5 ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

  always_ff @(posedge clk) begin
    if (advance) begin
      prod6  <= 36'(env5) * 36'(sine5);
      phase6 <= phase5;
      env6   <= env5;
    end
  end

  // Stage 7: floor shift, saturate, output register.
  logic signed [19:0] sshift;
  s18_t               sine_sat;

  assign sshift = prod6[35:16];

  always_comb begin
    if (sshift > 20'sd131071) begin
      sine_sat = 18'sd131071;
    end else if (sshift < -20'sd131072) begin
      sine_sat = -18'sd131072;
    end else begin
      sine_sat = sshift[17:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sine_out     <= sine_sat;
      phase_out    <= phase6;
      envelope_out <= env6;
    end
  end

`include "linear_chirp_sample_top_macros.svh"

  `LCS_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, v1, "accepted item missing in stage 1")
  `LCS_ASSERT_NEXT(a_stall_holds, !advance, $stable({v1, v2, v3, v4, v5, v6}), "pipeline moved while stalled")
  `LCS_ASSERT_NOW(a_zero_phase, out_valid && phase_out == 18'sd0, sine_out == 18'sd0, "nonzero sine at zero phase")

endmodule

### verif/testbench.sv
// Self-checking testbench for the linear chirp sample generator.
`timescale 1ns / 1ps

module testbench;
  import lcs_pkg::*;

  localparam int SINE_BITS     = 10;
  localparam int QUARTER_STEPS = 1 << SINE_BITS;
  localparam int NUM_CFG_REGS  = 5;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 100;
  localparam longint HALF_PI_FIX = 64'sd1686629713;

  typedef struct {
    logic [27:0]        freq;
    logic signed [17:0] amp;
    logic [31:0]        phase;
    logic signed [17:0] slope;
    logic signed [31:0] rate;
  } chirp_cfg_t;

  typedef struct {
    s18_t sine;
    s18_t phase;
    s18_t env;
  } chirp_sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [24:0] time_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  s18_t        sine_out;
  s18_t        phase_out;
  s18_t        envelope_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  longint        quarter_sine_q[0:QUARTER_STEPS];
  chirp_cfg_t    chirp_cfg;
  chirp_sample_t pending_samples[$];

  int  err_count = 0;
  int  items_sent = 0;
  int  samples_checked = 0;
  int  reg_writes = 0;
  int  settings_used = 0;
  int  cycle_count = 0;
  int  burst_left = 0;
  bit  gaps_on = 1'b0;
  bit  stalls_on = 1'b0;
  bit  ready_level = 1'b1;
  int  ready_run = 0;

  linear_chirp_sample_top #(
    .SINE_TABLE_BITS(SINE_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .time_in(time_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sine_out(sine_out),
    .phase_out(phase_out),
    .envelope_out(envelope_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d samples pending", cycle_count,
               pending_samples.size());
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: with stalls on, alternate ready runs and stall runs, with an occasional long stall; else always ready.
  always @(posedge clk) begin
    if (!stalls_on) begin
      out_ready <= 1'b1;
    end else begin
      if (ready_run == 0) begin
        ready_level = ~ready_level;
        if (ready_level) ready_run = $urandom_range(1, 10);
        else ready_run = ($urandom_range(0, 9) == 0) ? 24 : $urandom_range(1, 4);
      end
      ready_run--;
      out_ready <= ready_level;
    end
  end

  function automatic void flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("error: %s", msg);
  endfunction

  always @(posedge clk) begin : check_samples
    chirp_sample_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        flag_error($sformatf("unexpected sample sine %0d phase %0d envelope %0d",
                             sine_out, phase_out, envelope_out));
      end else begin
        want = pending_samples.pop_front();
        if (want.sine !== sine_out || want.phase !== phase_out ||
            want.env !== envelope_out)
          flag_error($sformatf(
            "sample %0d: sine %0d/%0d phase %0d/%0d envelope %0d/%0d (exp/got)",
            samples_checked, want.sine, sine_out, want.phase, phase_out,
            want.env, envelope_out));
        samples_checked++;
      end
    end
  end

  // Quarter-wave table: Taylor series in Q30, rounded to 16 fraction bits.
  task automatic fill_sine_table();
    longint x, x2, term, sum;
    for (int i = 0; i <= QUARTER_STEPS; i++) begin
      x = (HALF_PI_FIX * i) / QUARTER_STEPS;
      x2 = (x * x) >>> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 12; k++) begin
        term = ((term * x2) >>> 30) / ((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum -= term;
        else sum += term;
      end
      if (sum < 0) sum = 0;
      quarter_sine_q[i] = (sum * 65536 + (64'sd1 << 29)) >>> 30;
    end
  endtask

  function automatic longint clamp18(input longint v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic chirp_sample_t chirp_at(input logic [24:0] t);
    logic [63:0]   t_wide, freq_prod, t_sq, rate_ext, rate_prod;
    logic [31:0]   p;
    logic [1:0]    quad;
    int            idx;
    longint        tl, ph, env, sv, s;
    chirp_sample_t r;
    t_wide = {39'd0, t};
    tl = longint'(t);
    freq_prod = {36'd0, chirp_cfg.freq} * t_wide;
    t_sq = (t_wide * t_wide) >> 16;
    rate_ext = {{32{chirp_cfg.rate[31]}}, chirp_cfg.rate};
    rate_prod = rate_ext * t_sq;
    p = chirp_cfg.phase + freq_prod[39:8] + rate_prod[55:24];
    ph = longint'(p[31:15]);
    if (ph > 65536) ph -= 131072;
    env = clamp18(longint'(chirp_cfg.amp) + ((longint'(chirp_cfg.slope) * tl) >>> 24));
    quad = p[31:30];
    idx = int'(p[29 -: SINE_BITS]);
    sv = quad[0] ? quarter_sine_q[QUARTER_STEPS - idx] : quarter_sine_q[idx];
    if (quad[1]) sv = -sv;
    s = clamp18((env * sv) >>> 16);
    r.sine = s[17:0];
    r.phase = ph[17:0];
    r.env = env[17:0];
    return r;
  endfunction

  // Valid stays high across a burst; drop it only for a gap.
  task automatic send_time(input logic [24:0] t);
    if (gaps_on && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    time_in <= t;
    do @(posedge clk); while (!in_ready);
    pending_samples.push_back(chirp_at(t));
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_FREQUENCY: chirp_cfg.freq = data[27:0];
      REG_START_AMPLITUDE: chirp_cfg.amp = data[17:0];
      REG_START_PHASE:     chirp_cfg.phase = data;
      REG_AMPLITUDE_SLOPE: chirp_cfg.slope = data[17:0];
      REG_CHIRP_RATE:      chirp_cfg.rate = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic end_writes();
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  task automatic write_all(input logic [31:0] freq, input logic [31:0] amp,
                           input logic [31:0] phase, input logic [31:0] slope,
                           input logic [31:0] rate);
    wait_drained();
    write_reg(REG_START_FREQUENCY, freq);
    write_reg(REG_START_AMPLITUDE, amp);
    write_reg(REG_START_PHASE, phase);
    write_reg(REG_AMPLITUDE_SLOPE, slope);
    write_reg(REG_CHIRP_RATE, rate);
    end_writes();
  endtask

  function automatic logic [31:0] pick_reg_value(input int width, input bit is_signed);
    longint one;
    one = 1;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'(is_signed ? (one << (width - 1)) - 1 : (one << width) - 1);
      2: return 32'(is_signed ? (one << (width - 1)) : 64'sd0);
      3: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [24:0] pick_time();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(0, 9))
      0, 1: return {13'd0, w[11:0]};
      2:    return 25'h1FFFFFF - w[7:0];
      3:    return 25'h1000000 + w[7:0] - 25'd128;
      default: return w[24:0];
    endcase
  endfunction

  task automatic test_reset_values();
    send_time(25'd0);
    send_time(25'h1FFFFFF);
    send_time(25'h1000000);
    send_time(25'd1);
  endtask

  task automatic test_config_extremes();
    write_all(32'h0FFFFFFF, 32'd131071, 32'hFFFFFFFF, 32'd131071, 32'h7FFFFFFF);
    send_time(25'h1FFFFFF);
    send_time(25'h0800000);
    write_all(32'd0, 32'hFFFE0000, 32'd0, 32'hFFFE0000, 32'h80000000);
    send_time(25'h1FFFFFF);
    send_time(25'd1);
  endtask

  task automatic test_sine_saturation();
    // Envelope -2 at sine -1 must clamp to the positive limit.
    write_all(32'd0, 32'hFFFE0000, 32'hC0000000, 32'd0, 32'd0);
    send_time(25'd12345);
    wait_drained();
    write_reg(REG_START_PHASE, 32'h40000000);
    end_writes();
    send_time(25'd777);
    wait_drained();
    write_reg(REG_START_AMPLITUDE, 32'd131071);
    end_writes();
    send_time(25'd0);
  endtask

  task automatic test_phase_wrap();
    logic [31:0] wrap_pts[4];
    wrap_pts = '{32'h80000000, 32'h80008000, 32'h7FFFFFFF, 32'hFFFF8000};
    write_all(32'd0, 32'd65536, 32'd0, 32'd0, 32'd0);
    foreach (wrap_pts[i]) begin
      wait_drained();
      write_reg(REG_START_PHASE, wrap_pts[i]);
      end_writes();
      send_time(25'd0);
    end
  endtask

  task automatic test_unused_indexes();
    wait_drained();
    for (int i = NUM_CFG_REGS; i < 8; i++) write_reg(i[2:0], 32'hFFFFFFFF);
    end_writes();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    send_time(25'h1234567);
    send_time(25'h0ABCDEF);
  endtask

  task automatic test_random_chirps();
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_all(pick_reg_value(28, 1'b0), pick_reg_value(18, 1'b1),
                pick_reg_value(32, 1'b0), pick_reg_value(18, 1'b1),
                pick_reg_value(32, 1'b1));
      if ($urandom_range(0, 2) == 0) begin
        write_reg(3'($urandom_range(NUM_CFG_REGS, 7)), $urandom);
        end_writes();
      end
      gaps_on = ph[0];
      stalls_on = ph[1];
      for (int n = 0; n < PHASE_ITEMS; n++) send_time(pick_time());
    end
  endtask

  initial begin
    fill_sine_table();
    chirp_cfg.freq = 28'd65536;
    chirp_cfg.amp = 18'sd65536;
    chirp_cfg.phase = '0;
    chirp_cfg.slope = '0;
    chirp_cfg.rate = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_config_extremes();
    test_sine_saturation();
    test_phase_wrap();
    test_unused_indexes();
    test_random_chirps();

    wait_drained();
    $display("run covered %0d time values, %0d samples checked, %0d register writes",
             items_sent, samples_checked, reg_writes);
    $display("across %0d register settings; %0d errors", settings_used, err_count);
    if (err_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
